@@ rtl/dmx512_slot_receiver_assert.svh @@
// assertion macros for the dmx512 slot receiver checker
// depends on nothing; included by the checker file
`ifndef DMX512_SLOT_RECEIVER_ASSERT_SVH
`define DMX512_SLOT_RECEIVER_ASSERT_SVH

// same-cycle implication under async reset
`define DSR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("dsr same-cycle check failed");

// next-cycle implication under async reset
`define DSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("dsr next-cycle check failed");

`endif

@@ rtl/dsr_pkg.sv @@
// shared types and constants of the dmx512 slot receiver
// depends on nothing; used by the top level, queue, front, back and checker
package dsr_pkg;

	localparam int unsigned MAX_CHANNELS = 512;
	localparam int unsigned QUEUE_DEPTH  = 2;
	localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] START_DATA = 8'h00;
	localparam logic [7:0] START_TEST = 8'h17;
	localparam logic [9:0] SLOT_MAX   = 10'd1023;

	localparam logic [9:0] RST_START_ADDRESS     = 10'd1;
	localparam logic [9:0] RST_CHANNEL_COUNT     = 10'd16;
	localparam logic [7:0] RST_PACKETS_PER_BLINK = 8'd44;

	typedef enum logic [1:0] {
		CFG_START_ADDRESS     = 2'd0,
		CFG_CHANNEL_COUNT     = 2'd1,
		CFG_PACKETS_PER_BLINK = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_DATA = 2'd1,
		MODE_TEST = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		OP_BREAK      = 3'd0,
		OP_START_DATA = 3'd1,
		OP_START_TEST = 3'd2,
		OP_START_BAD  = 3'd3,
		OP_SLOT       = 3'd4
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic [9:0] start_address;
		logic [9:0] channel_count;
		logic [7:0] packets_per_blink;
	} cfg_t;

endpackage

@@ rtl/dsr_if.sv @@
// valid/ready channel interfaces of the dmx512 slot receiver
// depends on nothing; used by the front, back and top level
interface dsr_in_if;
	logic       valid;
	logic       ready;
	logic       framing_error;
	logic [7:0] rx_byte;

	modport source (output valid, output framing_error, output rx_byte, input ready);
	modport sink (input valid, input framing_error, input rx_byte, output ready);
endinterface

interface dsr_out_if;
	logic       valid;
	logic       ready;
	logic       write_enable;
	logic [8:0] channel_index;
	logic [7:0] channel_value;
	logic [1:0] packet_status;
	logic       led_state;

	modport source (output valid, output write_enable, output channel_index,
		output channel_value, output packet_status, output led_state, input ready);
	modport sink (input valid, input write_enable, input channel_index,
		input channel_value, input packet_status, input led_state, output ready);
endinterface

@@ rtl/dmx512_slot_receiver.sv @@
// dmx512 slot receiver: turns uart receive events into channel write beats
// Input channel in_ch: one beat per uart event, framing_error marks a break
// (rx_byte is then ignored), otherwise rx_byte is a received byte.
// Output channel out_ch: exactly one beat per input beat, in order, carrying
// write_enable, channel_index, channel_value, packet_status and led_state.
// A break arms start detection; the next byte is the start code (0x00 data,
// 0x17 test, anything else drops to idle until the next break).
// Config port: cfg_we writes cfg_wdata to register cfg_index (0 start
// address, 1 channel count, 2 packets per blink); write only while idle.
// Throughput: one beat per cycle while the output side is not stalled, set by
// the update of the slot and blink counters in the back end.
// Each taken input beat is written into a two-entry queue between front and
// back, then into the output register of the back end.
// Reset clears arming, packet mode, counters, led and all valid flags and
// loads the config registers with 1, 16 and 44; no clearing pass is needed.
// When the receiver stalls, the result holds in the output register, the
// queue fills, and in_ch.ready drops once both entries are taken.
module dmx512_slot_receiver
	import dsr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	dsr_in_if.sink     in_ch,
	dsr_out_if.source  out_ch,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_wdata
);

	cfg_t  cfg_q;
	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop_ready;
	item_t pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_address     <= RST_START_ADDRESS;
			cfg_q.channel_count     <= RST_CHANNEL_COUNT;
			cfg_q.packets_per_blink <= RST_PACKETS_PER_BLINK;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_ADDRESS: begin
					cfg_q.start_address <= cfg_wdata;
				end
				CFG_CHANNEL_COUNT: begin
					cfg_q.channel_count <= cfg_wdata;
				end
				CFG_PACKETS_PER_BLINK: begin
					cfg_q.packets_per_blink <= cfg_wdata[7:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	dsr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	dsr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	dsr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.out_ch    (out_ch)
	);

endmodule

@@ rtl/dsr_queue.sv @@
// short fifo between the classifying front and the executing back
// depends on dsr_pkg
module dsr_queue
	import dsr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	item_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               push;
	logic               pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/dsr_front.sv @@
// front: accepts uart events, tracks break arming, decodes start codes
// depends on dsr_pkg and dsr_if
module dsr_front
	import dsr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	dsr_in_if.sink in_ch,
	output logic  push_valid,
	input  logic  push_ready,
	output item_t push_item
);

	logic start_armed_q;
	logic accept;

	assign in_ch.ready = push_ready;
	assign push_valid  = in_ch.valid;
	assign accept      = in_ch.valid && push_ready;

	always_comb begin
		push_item.data = in_ch.rx_byte;
		if (in_ch.framing_error) begin
			push_item.op = OP_BREAK;
		end else if (start_armed_q) begin
			if (in_ch.rx_byte == START_DATA) begin
				push_item.op = OP_START_DATA;
			end else if (in_ch.rx_byte == START_TEST) begin
				push_item.op = OP_START_TEST;
			end else begin
				push_item.op = OP_START_BAD;
			end
		end else begin
			push_item.op = OP_SLOT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_armed_q <= 1'b0;
		end else if (accept) begin
			start_armed_q <= in_ch.framing_error;
		end
	end

endmodule

@@ rtl/dsr_back.sv @@
// back: packet mode, slot counter, blink counter and the registered result beat
// depends on dsr_pkg and dsr_if
module dsr_back
	import dsr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  pop_valid,
	output logic  pop_ready,
	input  item_t pop_item,
	dsr_out_if.source out_ch
);

	mode_t       mode_q;
	logic [9:0]  slot_q;
	logic [7:0]  blink_q;
	logic        led_q;

	logic        out_valid_q;
	logic        we_q;
	logic [8:0]  idx_q;
	logic [7:0]  val_q;

	mode_t       mode_n;
	logic [9:0]  slot_base;
	logic [9:0]  slot_n;
	logic [7:0]  blink_n;
	logic [7:0]  blink_inc;
	logic        led_n;
	logic        start;
	logic        take;
	logic [9:0]  cnt;
	logic [10:0] win_end;
	logic        in_win;
	logic [9:0]  offset;
	logic        we_n;
	logic        pop;

	assign pop_ready = !out_valid_q || out_ch.ready;
	assign pop       = pop_valid && pop_ready;

	always_comb begin
		mode_n    = mode_q;
		slot_base = slot_q;
		start     = 1'b0;
		take      = 1'b0;
		case (pop_item.op)
			OP_BREAK: begin
				take = 1'b0;
			end
			OP_START_DATA: begin
				start     = 1'b1;
				take      = 1'b1;
				mode_n    = MODE_DATA;
				slot_base = '0;
			end
			OP_START_TEST: begin
				start     = 1'b1;
				take      = 1'b1;
				mode_n    = MODE_TEST;
				slot_base = '0;
			end
			OP_START_BAD: begin
				start     = 1'b1;
				mode_n    = MODE_IDLE;
				slot_base = '0;
			end
			OP_SLOT: begin
				take = 1'b1;
			end
			default: begin
				take = 1'b0;
			end
		endcase
	end

	always_comb begin
		blink_inc = blink_q + 8'd1;
		blink_n   = blink_q;
		led_n     = led_q;
		if (start) begin
			if (blink_inc == cfg.packets_per_blink) begin
				blink_n = '0;
				led_n   = !led_q;
			end else begin
				blink_n = blink_inc;
			end
		end
	end

	always_comb begin
		cnt     = (cfg.channel_count > 10'(MAX_CHANNELS)) ? 10'(MAX_CHANNELS)
			: cfg.channel_count;
		win_end = {1'b0, cfg.start_address} + {1'b0, cnt};
		in_win  = (slot_base >= cfg.start_address) && ({1'b0, slot_base} < win_end);
		offset  = slot_base - cfg.start_address;
		we_n    = take && (mode_n == MODE_DATA) && in_win;
		slot_n  = slot_base;
		if (take && (slot_base < SLOT_MAX)) begin
			slot_n = slot_base + 10'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			slot_q      <= '0;
			blink_q     <= '0;
			led_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q      <= mode_n;
				slot_q      <= slot_n;
				blink_q     <= blink_n;
				led_q       <= led_n;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			we_q  <= we_n;
			idx_q <= we_n ? offset[8:0] : 9'd0;
			val_q <= we_n ? pop_item.data : 8'd0;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.write_enable  = we_q;
	assign out_ch.channel_index = idx_q;
	assign out_ch.channel_value = val_q;
	assign out_ch.packet_status = mode_q;
	assign out_ch.led_state     = led_q;

endmodule

@@ rtl/dsr_checker.sv @@
// port-level checker for the dmx512 slot receiver, bound to the top level
// depends on dsr_pkg and dmx512_slot_receiver_assert.svh
`include "dmx512_slot_receiver_assert.svh"

module dsr_port_checker
	import dsr_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       write_enable,
	input logic [8:0] channel_index,
	input logic [7:0] channel_value,
	input logic [1:0] packet_status,
	input logic       led_state
);

	`DSR_ASSERT_NOW(a_write_only_in_data, clk, arst_n,
		out_valid && write_enable, packet_status == MODE_DATA)

	`DSR_ASSERT_NOW(a_idle_beat_zeroed, clk, arst_n,
		out_valid && !write_enable, (channel_index == 9'd0) && (channel_value == 8'd0))

	`DSR_ASSERT_NEXT(a_stalled_beat_holds, clk, arst_n,
		out_valid && !out_ready,
		out_valid && $stable(write_enable) && $stable(channel_index)
		&& $stable(channel_value) && $stable(packet_status) && $stable(led_state))

endmodule

bind dmx512_slot_receiver dsr_port_checker u_dsr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.write_enable  (out_ch.write_enable),
	.channel_index (out_ch.channel_index),
	.channel_value (out_ch.channel_value),
	.packet_status (out_ch.packet_status),
	.led_state     (out_ch.led_state)
);

@@ test/dsr_checker.sv @@
// result checker for the dmx512 slot receiver: tracks register writes, predicts
// one result beat per input beat and compares it with the output channel
// depends on dsr_pkg and the dsr_in_if / dsr_out_if interfaces
`timescale 1ns / 1ps

module dsr_checker
	import dsr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	dsr_in_if          in_ch,
	dsr_out_if         out_ch,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_wdata,
	output int         errors,
	output int         pending
);

	typedef struct packed {
		logic       we;
		logic [8:0] idx;
		logic [7:0] val;
		mode_t      status;
		logic       led;
	} slot_result_t;

	cfg_t         regs;
	logic         armed;
	mode_t        mode;
	logic [9:0]   slot_cnt;
	logic [7:0]   blink_cnt;
	logic         led_level;
	slot_result_t expected_q[$];

	function automatic slot_result_t decode_slot(logic fe, logic [7:0] b);
		slot_result_t r;
		logic         take;
		int unsigned  span;
		int unsigned  lo;
		int unsigned  pos;
		r = '0;
		take = 1'b1;
		if (fe) begin
			armed = 1'b1;
			take = 1'b0;
		end else if (armed) begin
			blink_cnt = blink_cnt + 8'd1;
			if (blink_cnt == regs.packets_per_blink) begin
				blink_cnt = '0;
				led_level = ~led_level;
			end
			armed = 1'b0;
			slot_cnt = '0;
			if (b == START_DATA) begin
				mode = MODE_DATA;
			end else if (b == START_TEST) begin
				mode = MODE_TEST;
			end else begin
				mode = MODE_IDLE;
				take = 1'b0;
			end
		end
		if (take) begin
			if (mode == MODE_DATA) begin
				span = (regs.channel_count > MAX_CHANNELS) ? MAX_CHANNELS : regs.channel_count;
				lo = regs.start_address;
				pos = slot_cnt;
				if (pos >= lo && pos < lo + span) begin
					r.we = 1'b1;
					r.idx = 9'(pos - lo);
					r.val = b;
				end
			end
			if (slot_cnt != SLOT_MAX)
				slot_cnt = slot_cnt + 10'd1;
		end
		r.status = mode;
		r.led = led_level;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		slot_result_t got;
		slot_result_t want;
		if (!arst_n) begin
			regs.start_address = RST_START_ADDRESS;
			regs.channel_count = RST_CHANNEL_COUNT;
			regs.packets_per_blink = RST_PACKETS_PER_BLINK;
			armed = 1'b0;
			mode = MODE_IDLE;
			slot_cnt = '0;
			blink_cnt = '0;
			led_level = 1'b0;
			expected_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			// older beat leaves first, a new input cannot show up in the same cycle
			if (out_ch.valid && out_ch.ready) begin
				got.we = out_ch.write_enable;
				got.idx = out_ch.channel_index;
				got.val = out_ch.channel_value;
				got.status = mode_t'(out_ch.packet_status);
				got.led = out_ch.led_state;
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected result beat we=%0d index=%0d value=%0h status=%0d led=%0d",
							$time, got.we, got.idx, got.val, got.status, got.led);
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display({"%0t: result mismatch, expected we=%0d index=%0d value=%0h ",
								"status=%0d led=%0d, got we=%0d index=%0d value=%0h status=%0d led=%0d"},
								$time, want.we, want.idx, want.val, want.status, want.led,
								got.we, got.idx, got.val, got.status, got.led);
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				expected_q.push_back(decode_slot(in_ch.framing_error, in_ch.rx_byte));
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_START_ADDRESS: regs.start_address = cfg_wdata;
					CFG_CHANNEL_COUNT: regs.channel_count = cfg_wdata;
					CFG_PACKETS_PER_BLINK: regs.packets_per_blink = cfg_wdata[7:0];
					default: ;
				endcase
			end
			pending = expected_q.size();
		end
	end

endmodule

@@ test/tb_top.sv @@
// top of the dmx512 slot receiver testbench: clock, reset, register writes,
// uart event stimulus with random gaps and stalls, and the final verdict
// depends on dsr_pkg, the channel interfaces, the block and dsr_checker
`timescale 1ns / 1ps

module tb_top;
	import dsr_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [9:0] cfg_wdata;
	int         errors;
	int         pending;
	int         src_idle;
	int         snk_idle;
	int         beats_sent;
	int         cur_sa;
	int         cur_cc;

	dsr_in_if  in_ch();
	dsr_out_if out_ch();

	dmx512_slot_receiver i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	dsr_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("dmx512_slot_receiver test failed");
		$finish;
	end

	// receiver stalls, redrawn every cycle
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready <= ($urandom_range(99) >= snk_idle);
		end
	end

	task automatic send_beat(logic fe, logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.framing_error <= fe;
		in_ch.rx_byte <= b;
		do
			@(posedge clk);
		while (!in_ch.ready);
		beats_sent++;
	endtask

	// break, start code, then len slot bytes
	task automatic send_packet(logic [7:0] code, int len);
		send_beat(1'b1, 8'($urandom_range(255)));
		send_beat(1'b0, code);
		repeat (len)
			send_beat(1'b0, 8'($urandom_range(255)));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4)
			@(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [9:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
	endtask

	task automatic set_regs(int sa, int cc, int ppb);
		wait_idle();
		write_reg(CFG_START_ADDRESS, 10'(sa));
		write_reg(CFG_CHANNEL_COUNT, 10'(cc));
		write_reg(CFG_PACKETS_PER_BLINK, {2'b00, 8'(ppb)});
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_sa = sa;
		cur_cc = cc;
	endtask

	task automatic run_traffic(int n);
		int         stop;
		int         r;
		int         reach;
		logic [7:0] code;
		stop = beats_sent + n;
		reach = cur_sa + ((cur_cc > MAX_CHANNELS) ? MAX_CHANNELS : cur_cc) + 2;
		if (reach > 48)
			reach = 48;
		while (beats_sent < stop) begin
			r = $urandom_range(99);
			if (r < 60) begin
				send_packet(START_DATA, $urandom_range(0, reach));
			end else if (r < 70) begin
				send_packet(START_TEST, $urandom_range(0, 8));
			end else if (r < 80) begin
				code = 8'($urandom_range(1, 255));
				if (code == START_TEST)
					code = ~code;
				send_packet(code, $urandom_range(0, 6));
			end else if (r < 90) begin
				send_beat($urandom_range(3) == 0, 8'($urandom_range(255)));
			end else begin
				// double break ahead of a data packet
				send_beat(1'b1, 8'($urandom_range(255)));
				send_packet(START_DATA, $urandom_range(0, reach));
			end
		end
	endtask

	initial begin : stimulus
		int m;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_START_ADDRESS;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.framing_error = 1'b0;
		in_ch.rx_byte = '0;
		src_idle = 37;
		snk_idle = 65;
		beats_sent = 0;
		cur_sa = RST_START_ADDRESS;
		cur_cc = RST_CHANNEL_COUNT;
		repeat (4)
			@(negedge clk);
		arst_n <= 1'b1;

		// reset register values
		send_beat(1'b0, 8'hFF);
		send_beat(1'b1, 8'h00);
		send_beat(1'b0, START_DATA);
		send_beat(1'b0, 8'hFF);
		send_beat(1'b0, 8'h00);
		send_beat(1'b0, 8'hA5);
		send_beat(1'b0, 8'h5A);
		send_beat(1'b1, 8'hFF);
		send_beat(1'b1, 8'h17);
		send_beat(1'b0, START_TEST);
		send_beat(1'b0, 8'h80);
		send_beat(1'b1, 8'h3C);
		send_beat(1'b0, 8'h42);
		send_beat(1'b0, 8'h00);
		send_beat(1'b1, 8'hC3);
		send_beat(1'b0, 8'hFF);
		send_beat(1'b0, START_DATA);

		// start code inside the window, oversized count, led toggles every start
		set_regs(0, 1023, 1);
		send_beat(1'b1, 8'h00);
		send_beat(1'b0, START_DATA);
		send_beat(1'b0, 8'h7E);
		send_beat(1'b1, 8'h00);
		send_beat(1'b0, START_TEST);
		send_beat(1'b1, 8'hEE);

		for (m = 0; m < 3; m++) begin
			wait_idle();
			src_idle = (m == 0) ? 37 : (m == 1) ? 65 : 0;
			snk_idle = (m == 0) ? 65 : (m == 1) ? 37 : 0;
			set_regs($urandom_range(1, 20), $urandom_range(0, 24), $urandom_range(1, 6));
			run_traffic(130);
			set_regs(1, 512, 255);
			run_traffic(80);
			if (m == 0) begin
				// window at the top of the slot range, counter runs into saturation
				set_regs(512, 512, 2);
				send_packet(START_DATA, 1030);
			end
			if (m == 2) begin
				set_regs($urandom_range(1, 8), 0, 0);
				run_traffic(100);
			end
		end

		wait_idle();
		repeat (10)
			@(negedge clk);
		if (errors == 0)
			$display("dmx512_slot_receiver test passed");
		else
			$display("dmx512_slot_receiver test failed");
		$finish;
	end

endmodule
